// ===== rtl/core/cfgtok_pkg.sv =====
// ============================================================================
// cfgtok_pkg: shared types and constants of the configuration text tokenizer
// Parse and comment phase codes, event and error codes, character constants,
// the tokenizer state record and the result record.
// ============================================================================
package cfgtok_pkg;

  // Deepest section nesting that an open brace may still create.
  localparam logic [7:0]  MAX_DEPTH = 8'd255;
  // Line counter saturates here.
  localparam logic [19:0] LINE_TOP  = 20'hFFFFF;
  // Most handlings of one byte that the step logic allows.
  localparam int          PASS_MAX  = 4;
  // Result queue geometry.
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_W      = 2;
  localparam int          QCNT_W      = 3;

  // Parse phases.
  localparam logic [3:0] PH_NAME  = 4'd0;
  localparam logic [3:0] PH_VALUE = 4'd1;
  localparam logic [3:0] PH_AFTER = 4'd2;
  localparam logic [3:0] PH_CLOSE = 4'd3;
  localparam logic [3:0] PH_UQ    = 4'd4;
  localparam logic [3:0] PH_Q     = 4'd5;
  localparam logic [3:0] PH_QESC  = 4'd6;

  // Comment phases.
  localparam logic [2:0] CM_NONE       = 3'd0;
  localparam logic [2:0] CM_SLASH      = 3'd1;
  localparam logic [2:0] CM_SLASH_NAME = 3'd2;
  localparam logic [2:0] CM_BLOCK      = 3'd3;
  localparam logic [2:0] CM_STAR       = 3'd4;
  localparam logic [2:0] CM_LINE       = 3'd5;

  // Event kinds.
  localparam logic [3:0] EV_NCHAR = 4'd0;
  localparam logic [3:0] EV_NEND  = 4'd1;
  localparam logic [3:0] EV_VCHAR = 4'd2;
  localparam logic [3:0] EV_VEND  = 4'd3;
  localparam logic [3:0] EV_OPEN  = 4'd4;
  localparam logic [3:0] EV_CLOSE = 4'd5;
  localparam logic [3:0] EV_ENTRY = 4'd6;
  localparam logic [3:0] EV_DONE  = 4'd7;
  localparam logic [3:0] EV_ERROR = 4'd8;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_OPEN_COMMENT = 4'd0;
  localparam logic [3:0] ERR_EOF_QUOTE    = 4'd1;
  localparam logic [3:0] ERR_NL_QUOTE     = 4'd2;
  localparam logic [3:0] ERR_EXTRA_CLOSE  = 4'd3;
  localparam logic [3:0] ERR_NO_SEMI      = 4'd4;
  localparam logic [3:0] ERR_BAD_NAME     = 4'd5;
  localparam logic [3:0] ERR_NAME_JUNK    = 4'd6;
  localparam logic [3:0] ERR_BAD_VALUE    = 4'd7;
  localparam logic [3:0] ERR_VALUE_JUNK   = 4'd8;
  localparam logic [3:0] ERR_UNCLOSED     = 4'd9;
  localparam logic [3:0] ERR_TOO_DEEP     = 4'd10;

  // Characters.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [3:0]  parse_phase;
    logic [2:0]  comment_phase;
    logic [3:0]  return_phase;
    logic        token_is_value;
    logic [7:0]  depth_count;
    logic [19:0] line_count;
    logic        error_latched;
  } tok_state_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [7:0]  token_char;
    logic [3:0]  error_code;
    logic [19:0] line_number;
    logic [7:0]  nest_depth;
    logic        last_of_run;
  } tok_result_t;

  // Working record while one byte is handled: state, results so far,
  // their count, and whether the byte must be handled once more.
  typedef struct packed {
    tok_state_t            st;
    tok_result_t [1:0]     res;
    logic [1:0]            count;
    logic                  again;
  } tok_work_t;

  localparam tok_state_t STATE_RESET = '{
    parse_phase:    PH_NAME,
    comment_phase:  CM_NONE,
    return_phase:   PH_NAME,
    token_is_value: 1'b0,
    depth_count:    8'd0,
    line_count:     20'd1,
    error_latched:  1'b0
  };

endpackage

// ===== rtl/core/cfgtok_step.sv =====
// ============================================================================
// cfgtok_step: next-state and result logic for one text byte
// Handles one byte against the current tokenizer state and gives the next
// state together with up to two results.
// ============================================================================
module cfgtok_step (
  input  cfgtok_pkg::tok_state_t            state_cur,
  input  logic [7:0]                        byte_in,
  output cfgtok_pkg::tok_state_t            state_next,
  output cfgtok_pkg::tok_result_t [1:0]     results,
  output logic [1:0]                        result_count
);

  function automatic cfgtok_pkg::tok_work_t emit_ev(cfgtok_pkg::tok_work_t w,
                                                    logic [3:0] kind,
                                                    logic [7:0] ch,
                                                    logic [3:0] err);
    cfgtok_pkg::tok_work_t r;
    r = w;
    if (r.count < 2'd2) begin
      r.res[r.count[0]] = '{event_kind:  kind,
                            token_char:  ch,
                            error_code:  err,
                            line_number: r.st.line_count,
                            nest_depth:  r.st.depth_count,
                            last_of_run: 1'b0};
      r.count = r.count + 2'd1;
    end
    return r;
  endfunction

  function automatic cfgtok_pkg::tok_work_t fail_ev(cfgtok_pkg::tok_work_t w,
                                                    logic [3:0] err);
    cfgtok_pkg::tok_work_t r;
    r = emit_ev(w, cfgtok_pkg::EV_ERROR, 8'd0, err);
    r.st.error_latched = 1'b1;
    return r;
  endfunction

  function automatic cfgtok_pkg::tok_work_t next_line(cfgtok_pkg::tok_work_t w);
    cfgtok_pkg::tok_work_t r;
    r = w;
    if (r.st.line_count < cfgtok_pkg::LINE_TOP) begin
      r.st.line_count = r.st.line_count + 20'd1;
    end
    return r;
  endfunction

  function automatic logic is_skip(logic [7:0] c);
    return (c == cfgtok_pkg::CH_SPACE) || (c == cfgtok_pkg::CH_TAB) ||
           (c == cfgtok_pkg::CH_CR) || (c == cfgtok_pkg::CH_EQUAL) ||
           (c == cfgtok_pkg::CH_LF) || (c == cfgtok_pkg::CH_SLASH) ||
           (c == cfgtok_pkg::CH_HASH);
  endfunction

  function automatic logic is_token_end(logic [7:0] c);
    return (c == cfgtok_pkg::CH_NUL) || (c == cfgtok_pkg::CH_TAB) ||
           (c == cfgtok_pkg::CH_CR) || (c == cfgtok_pkg::CH_LF) ||
           (c == cfgtok_pkg::CH_SPACE) || (c == cfgtok_pkg::CH_SLASH) ||
           (c == cfgtok_pkg::CH_HASH) || (c == cfgtok_pkg::CH_SEMI) ||
           (c == cfgtok_pkg::CH_LBRACE) || (c == cfgtok_pkg::CH_RBRACE);
  endfunction

  // Whitespace and equals signs are consumed; a slash or hash starts a comment
  // that returns to the phase in which it began.
  function automatic cfgtok_pkg::tok_work_t apply_skip(cfgtok_pkg::tok_work_t w,
                                                       logic [7:0] c);
    cfgtok_pkg::tok_work_t r;
    r = w;
    if (c == cfgtok_pkg::CH_LF) begin
      r = next_line(r);
    end else if (c == cfgtok_pkg::CH_SLASH) begin
      r.st.comment_phase = cfgtok_pkg::CM_SLASH;
      r.st.return_phase  = r.st.parse_phase;
    end else if (c == cfgtok_pkg::CH_HASH) begin
      r.st.comment_phase = cfgtok_pkg::CM_LINE;
      r.st.return_phase  = r.st.parse_phase;
    end
    return r;
  endfunction

  function automatic logic [3:0] lone_code(cfgtok_pkg::tok_state_t st);
    logic [3:0] code;
    if (st.comment_phase == cfgtok_pkg::CM_SLASH_NAME) begin
      code = cfgtok_pkg::ERR_NAME_JUNK;
    end else if (st.return_phase == cfgtok_pkg::PH_VALUE) begin
      code = cfgtok_pkg::ERR_BAD_VALUE;
    end else if (st.return_phase == cfgtok_pkg::PH_AFTER) begin
      code = cfgtok_pkg::ERR_VALUE_JUNK;
    end else if (st.return_phase == cfgtok_pkg::PH_CLOSE) begin
      code = cfgtok_pkg::ERR_NO_SEMI;
    end else begin
      code = cfgtok_pkg::ERR_BAD_NAME;
    end
    return code;
  endfunction

  function automatic cfgtok_pkg::tok_work_t open_section(cfgtok_pkg::tok_work_t w);
    cfgtok_pkg::tok_work_t r;
    r = w;
    if (r.st.depth_count >= cfgtok_pkg::MAX_DEPTH) begin
      r = fail_ev(r, cfgtok_pkg::ERR_TOO_DEEP);
    end else begin
      r.st.depth_count = r.st.depth_count + 8'd1;
      r = emit_ev(r, cfgtok_pkg::EV_OPEN, 8'd0, cfgtok_pkg::ERR_NONE);
      r.st.parse_phase = cfgtok_pkg::PH_NAME;
    end
    return r;
  endfunction

  function automatic cfgtok_pkg::tok_work_t end_entry(cfgtok_pkg::tok_work_t w);
    cfgtok_pkg::tok_work_t r;
    r = emit_ev(w, cfgtok_pkg::EV_ENTRY, 8'd0, cfgtok_pkg::ERR_NONE);
    r.st.parse_phase = cfgtok_pkg::PH_NAME;
    return r;
  endfunction

  // One handling of the byte; sets again when the same byte must be
  // handled once more in the new phase.
  function automatic cfgtok_pkg::tok_work_t handle(cfgtok_pkg::tok_work_t w,
                                                   logic [7:0] c);
    cfgtok_pkg::tok_work_t r;
    logic                  parse_go;
    logic [3:0]            ch_kind;
    logic [3:0]            end_kind;
    r        = w;
    r.again  = 1'b0;
    parse_go = 1'b0;
    ch_kind  = r.st.token_is_value ? cfgtok_pkg::EV_VCHAR : cfgtok_pkg::EV_NCHAR;
    end_kind = r.st.token_is_value ? cfgtok_pkg::EV_VEND : cfgtok_pkg::EV_NEND;

    unique case (r.st.comment_phase)
      cfgtok_pkg::CM_SLASH, cfgtok_pkg::CM_SLASH_NAME: begin
        if (c == cfgtok_pkg::CH_STAR) begin
          r.st.comment_phase = cfgtok_pkg::CM_BLOCK;
        end else if (c == cfgtok_pkg::CH_SLASH) begin
          r.st.comment_phase = cfgtok_pkg::CM_LINE;
        end else begin
          r = fail_ev(r, lone_code(r.st));
        end
      end
      cfgtok_pkg::CM_BLOCK: begin
        if (c == cfgtok_pkg::CH_STAR) begin
          r.st.comment_phase = cfgtok_pkg::CM_STAR;
        end else if (c == cfgtok_pkg::CH_LF) begin
          r = next_line(r);
        end else if (c == cfgtok_pkg::CH_NUL) begin
          r = fail_ev(r, cfgtok_pkg::ERR_OPEN_COMMENT);
        end
      end
      cfgtok_pkg::CM_STAR: begin
        if (c == cfgtok_pkg::CH_SLASH) begin
          r.st.comment_phase = cfgtok_pkg::CM_NONE;
          r.st.parse_phase   = r.st.return_phase;
        end else if (c == cfgtok_pkg::CH_NUL) begin
          r = fail_ev(r, cfgtok_pkg::ERR_OPEN_COMMENT);
        end else if (c != cfgtok_pkg::CH_STAR) begin
          if (c == cfgtok_pkg::CH_LF) begin
            r = next_line(r);
          end
          r.st.comment_phase = cfgtok_pkg::CM_BLOCK;
        end
      end
      cfgtok_pkg::CM_LINE: begin
        if ((c == cfgtok_pkg::CH_LF) || (c == cfgtok_pkg::CH_CR) ||
            (c == cfgtok_pkg::CH_NUL)) begin
          r.st.comment_phase = cfgtok_pkg::CM_NONE;
          r.st.parse_phase   = r.st.return_phase;
          r.again            = 1'b1;
        end
      end
      default: begin
        r.st.comment_phase = cfgtok_pkg::CM_NONE;
        parse_go           = 1'b1;
      end
    endcase

    if (parse_go) begin
      unique case (r.st.parse_phase)
        cfgtok_pkg::PH_NAME: begin
          if (is_skip(c)) begin
            r = apply_skip(r, c);
          end else if (c == cfgtok_pkg::CH_NUL) begin
            if (r.st.depth_count != 8'd0) begin
              r = fail_ev(r, cfgtok_pkg::ERR_UNCLOSED);
            end else begin
              r = emit_ev(r, cfgtok_pkg::EV_DONE, 8'd0, cfgtok_pkg::ERR_NONE);
            end
          end else if (c == cfgtok_pkg::CH_RBRACE) begin
            if (r.st.depth_count == 8'd0) begin
              r = fail_ev(r, cfgtok_pkg::ERR_EXTRA_CLOSE);
            end else begin
              r.st.depth_count = r.st.depth_count - 8'd1;
              r = emit_ev(r, cfgtok_pkg::EV_CLOSE, 8'd0, cfgtok_pkg::ERR_NONE);
              r.st.parse_phase = cfgtok_pkg::PH_CLOSE;
            end
          end else if (c == cfgtok_pkg::CH_QUOTE) begin
            r.st.token_is_value = 1'b0;
            r.st.parse_phase    = cfgtok_pkg::PH_Q;
          end else if ((c == cfgtok_pkg::CH_SEMI) || (c == cfgtok_pkg::CH_LBRACE)) begin
            r = fail_ev(r, cfgtok_pkg::ERR_BAD_NAME);
          end else begin
            r.st.token_is_value = 1'b0;
            r = emit_ev(r, cfgtok_pkg::EV_NCHAR, c, cfgtok_pkg::ERR_NONE);
            r.st.parse_phase = cfgtok_pkg::PH_UQ;
          end
        end
        cfgtok_pkg::PH_VALUE: begin
          if (is_skip(c)) begin
            r = apply_skip(r, c);
          end else if (c == cfgtok_pkg::CH_LBRACE) begin
            r = open_section(r);
          end else if (c == cfgtok_pkg::CH_SEMI) begin
            r = end_entry(r);
          end else if (c == cfgtok_pkg::CH_QUOTE) begin
            r.st.token_is_value = 1'b1;
            r.st.parse_phase    = cfgtok_pkg::PH_Q;
          end else if ((c == cfgtok_pkg::CH_RBRACE) || (c == cfgtok_pkg::CH_NUL)) begin
            r = fail_ev(r, cfgtok_pkg::ERR_BAD_VALUE);
          end else begin
            r.st.token_is_value = 1'b1;
            r = emit_ev(r, cfgtok_pkg::EV_VCHAR, c, cfgtok_pkg::ERR_NONE);
            r.st.parse_phase = cfgtok_pkg::PH_UQ;
          end
        end
        cfgtok_pkg::PH_AFTER: begin
          if (is_skip(c)) begin
            r = apply_skip(r, c);
          end else if (c == cfgtok_pkg::CH_LBRACE) begin
            r = open_section(r);
          end else if (c == cfgtok_pkg::CH_SEMI) begin
            r = end_entry(r);
          end else begin
            r = fail_ev(r, cfgtok_pkg::ERR_VALUE_JUNK);
          end
        end
        cfgtok_pkg::PH_CLOSE: begin
          if (is_skip(c)) begin
            r = apply_skip(r, c);
          end else if (c == cfgtok_pkg::CH_SEMI) begin
            r = end_entry(r);
          end else begin
            r = fail_ev(r, cfgtok_pkg::ERR_NO_SEMI);
          end
        end
        cfgtok_pkg::PH_UQ: begin
          if (is_token_end(c)) begin
            r = emit_ev(r, end_kind, 8'd0, cfgtok_pkg::ERR_NONE);
            if (!r.st.token_is_value && (c == cfgtok_pkg::CH_RBRACE)) begin
              r = fail_ev(r, cfgtok_pkg::ERR_NAME_JUNK);
            end else if (!r.st.token_is_value && (c == cfgtok_pkg::CH_SLASH)) begin
              r.st.comment_phase = cfgtok_pkg::CM_SLASH_NAME;
              r.st.return_phase  = cfgtok_pkg::PH_VALUE;
            end else begin
              r.st.parse_phase = r.st.token_is_value ? cfgtok_pkg::PH_AFTER
                                                     : cfgtok_pkg::PH_VALUE;
              r.again = 1'b1;
            end
          end else begin
            r = emit_ev(r, ch_kind, c, cfgtok_pkg::ERR_NONE);
          end
        end
        cfgtok_pkg::PH_Q: begin
          if (c == cfgtok_pkg::CH_QUOTE) begin
            r = emit_ev(r, end_kind, 8'd0, cfgtok_pkg::ERR_NONE);
            r.st.parse_phase = r.st.token_is_value ? cfgtok_pkg::PH_AFTER
                                                   : cfgtok_pkg::PH_VALUE;
          end else if (c == cfgtok_pkg::CH_BSLASH) begin
            r.st.parse_phase = cfgtok_pkg::PH_QESC;
          end else if (c == cfgtok_pkg::CH_NUL) begin
            r = fail_ev(r, cfgtok_pkg::ERR_EOF_QUOTE);
          end else if ((c == cfgtok_pkg::CH_CR) || (c == cfgtok_pkg::CH_LF)) begin
            r = fail_ev(r, cfgtok_pkg::ERR_NL_QUOTE);
          end else begin
            r = emit_ev(r, ch_kind, c, cfgtok_pkg::ERR_NONE);
          end
        end
        cfgtok_pkg::PH_QESC: begin
          r.st.parse_phase = cfgtok_pkg::PH_Q;
          if ((c == cfgtok_pkg::CH_QUOTE) || (c == cfgtok_pkg::CH_BSLASH)) begin
            r = emit_ev(r, ch_kind, c, cfgtok_pkg::ERR_NONE);
          end else begin
            // The backslash stands for itself; the byte is then taken as usual.
            r = emit_ev(r, ch_kind, cfgtok_pkg::CH_BSLASH, cfgtok_pkg::ERR_NONE);
            r.again = 1'b1;
          end
        end
        default: begin
          r.st.parse_phase = cfgtok_pkg::PH_NAME;
          r.again          = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  always_comb begin
    cfgtok_pkg::tok_work_t w;
    logic                  active;
    w.st    = state_cur;
    w.res   = '0;
    w.count = 2'd0;
    w.again = 1'b0;
    active  = !state_cur.error_latched;
    for (int i = 0; i < cfgtok_pkg::PASS_MAX; i++) begin
      if (active) begin
        w      = handle(w, byte_in);
        active = w.again && !w.st.error_latched;
      end
    end
    if (w.count == 2'd1) begin
      w.res[0].last_of_run = 1'b1;
    end else if (w.count == 2'd2) begin
      w.res[1].last_of_run = 1'b1;
    end
    if (byte_in == cfgtok_pkg::CH_NUL) begin
      w.st = cfgtok_pkg::STATE_RESET;
    end
    state_next   = w.st;
    results      = w.res;
    result_count = w.count;
  end

endmodule

// ===== rtl/core/cfgtok_queue.sv =====
// ============================================================================
// cfgtok_queue: result queue of the configuration text tokenizer
// Takes up to two results per cycle and hands out one per cycle while popped.
// ============================================================================
module cfgtok_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        push_count,
  input  cfgtok_pkg::tok_result_t [1:0]     push_data,
  input  logic                              pop,
  output cfgtok_pkg::tok_result_t           head,
  output logic                              not_empty,
  output logic                              room
);

  cfgtok_pkg::tok_result_t mem [cfgtok_pkg::QUEUE_DEPTH];

  logic [cfgtok_pkg::QPTR_W-1:0] wr_ptr;
  logic [cfgtok_pkg::QPTR_W-1:0] rd_ptr;
  logic [cfgtok_pkg::QCNT_W-1:0] count;
  logic [cfgtok_pkg::QPTR_W-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + 1'b1;
  assign head         = mem[rd_ptr];
  assign not_empty    = (count != '0);
  // Two free entries are needed for the worst case of one byte.
  assign room = (count <= cfgtok_pkg::QCNT_W'(cfgtok_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_data[0];
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_plus1] <= push_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cfgtok_pkg::QPTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + cfgtok_pkg::QCNT_W'(push_count) - cfgtok_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/core/config_text_tokenizer.sv =====
// ============================================================================
// config_text_tokenizer: streaming tokenizer for brace-nested configuration
// Takes one byte of text per request and reports token, brace, entry, done
// and error events with line number and nesting depth.
// ============================================================================
// A byte waits in the input register until the queue has room, then its results
// are queued. Throughput: one byte per cycle while each byte gives at most one
// result and the output is not stalled; a byte with two results hands them out
// one at a time through the single output port. Reset (rst, synchronous) clears
// the tokenizer state, the input stage and the result queue; no clearing pass follows.
module config_text_tokenizer (
  input  logic        clk,
  input  logic        rst,
  // Input channel: one text byte per request.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  // Output channel: one event per request.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_kind,
  output logic [7:0]  token_char,
  output logic [3:0]  error_code,
  output logic [19:0] line_number,
  output logic [7:0]  nest_depth,
  output logic        last_of_run
);

  // Input register. A byte waits here until the result queue has room for
  // the two results that one byte may cause in the worst case.
  logic       in_full;
  logic [7:0] in_char;

  // Tokenizer state: phases, nesting depth, line count and error latch.
  cfgtok_pkg::tok_state_t        state;
  cfgtok_pkg::tok_state_t        state_next;
  cfgtok_pkg::tok_result_t [1:0] step_results;
  logic [1:0]                    step_count;

  logic                          room;
  logic                          advance;
  logic [1:0]                    push_count;
  logic                          pop;
  cfgtok_pkg::tok_result_t       head;

  // The input stage is blocked only while it holds a byte that the queue
  // cannot yet absorb; this depends on registers alone.
  assign advance  = in_full && room;
  assign in_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_char <= char_in;
    end
  end

  // The whole handling of one byte, including the re-handling of a byte
  // that ends a token or a line comment, happens in this one step.
  cfgtok_step u_step (
    .state_cur    (state),
    .byte_in      (in_char),
    .state_next   (state_next),
    .results      (step_results),
    .result_count (step_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfgtok_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  assign push_count = advance ? step_count : 2'd0;
  assign pop        = out_valid && !out_stall;

  // The queue is the result register; its head is held while stalled.
  cfgtok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_data  (step_results),
    .pop        (pop),
    .head       (head),
    .not_empty  (out_valid),
    .room       (room)
  );

  assign event_kind  = head.event_kind;
  assign token_char  = head.token_char;
  assign error_code  = head.error_code;
  assign line_number = head.line_number;
  assign nest_depth  = head.nest_depth;
  assign last_of_run = head.last_of_run;

endmodule
